// ===== hdl/bvp_pkg.sv =====
// ----------------------------------------------------------------------------
// bvp_pkg
// Shared widths, constants and types of the binocular vergence point core.
// ----------------------------------------------------------------------------
package bvp_pkg;

    function automatic int imax(input int x, input int y);
        return (x > y) ? x : y;
    endfunction

    localparam int IN_FRAC_BITS  = 4;
    localparam int OUT_FRAC_BITS = 16;
    localparam int GW            = 20;
    localparam int TDW           = 16;
    localparam int OUTW          = 32;
    localparam int QB            = 33;
    localparam int MUL_CHUNK     = 24;

    localparam int SSW  = TDW + IN_FRAC_BITS + 1;
    localparam int AW   = imax(GW, SSW) + 1;
    localparam int CW   = imax(GW, SSW + 1) + 1;
    localparam int AMCW = imax(AW, CW) + 1;
    localparam int DMBW = GW + 1;
    localparam int EW   = imax(CW + GW, GW + AW) + 1;
    localparam int S2W  = 2 * SSW;
    localparam int SQW  = imax(2 * AMCW, 2 * DMBW) + 1;
    localparam int QW   = imax(S2W + SQW, 2 * EW) + 1;
    localparam int UAW  = imax(S2W + AMCW, GW + EW) + 1;
    localparam int SUW  = UAW + 1;
    localparam int S4W  = 2 * S2W;
    localparam int MILW = 21;
    localparam int Q6W  = QW + MILW;
    localparam int NW   = imax(imax(CW, AW) + UAW + 1, SSW + SUW);
    localparam int TW   = imax(NW + OUT_FRAC_BITS, QW) + 1;
    localparam int DW   = QW;
    localparam int RW   = imax(TW, DW + QB) + 1;
    localparam int VW   = QB + 2;

    localparam logic [GW-1:0]          MISS_CODE   = {1'b1, {(GW-1){1'b0}}};
    localparam logic signed [MILW-1:0] ONE_MILLION = 21'sd1000000;
    localparam logic [TDW-1:0]         TD_RESET    = 16'd1024;

    localparam longint SENT_RAW = -(longint'(32768) << OUT_FRAC_BITS);
    localparam logic [OUTW-1:0] SENTINEL =
        (SENT_RAW < -(longint'(1) << (OUTW - 1))) ? {1'b1, {(OUTW-1){1'b0}}}
                                                  : OUTW'(SENT_RAW);
    localparam int X_BIAS = 1 << (OUT_FRAC_BITS - 1);
    localparam int Z_BIAS = -(1 << OUT_FRAC_BITS);

    typedef enum logic [1:0] {
        ST_COMPUTED   = 2'd0,
        ST_MISSING    = 2'd1,
        ST_DEGENERATE = 2'd2
    } status_t;

    typedef struct packed {
        logic signed [AW-1:0]  a;
        logic signed [GW-1:0]  b;
        logic signed [CW-1:0]  c;
        logic signed [GW-1:0]  d;
        logic signed [SSW-1:0] s;
        logic                  miss;
    } geo_t;

    function automatic logic [OUTW-1:0] sat32(input logic signed [VW:0] v);
        logic hi_ones;
        logic hi_zero;
        hi_ones = &v[VW:OUTW-1];
        hi_zero = ~|v[VW:OUTW-1];
        if (hi_ones || hi_zero) begin
            return v[OUTW-1:0];
        end
        return v[VW] ? {1'b1, {(OUTW-1){1'b0}}} : {1'b0, {(OUTW-1){1'b1}}};
    endfunction

endpackage

// ===== hdl/binocular_vergence_point_core.sv =====
// ----------------------------------------------------------------------------
// binocular_vergence_point_core
// Midpoint of the shortest segment between the two gaze lines of one sample.
// ----------------------------------------------------------------------------
// The s_ channel takes one binocular gaze word (left and right x, y) per
// valid/ready handshake; the m_ channel returns one result word per input:
// the vergence point x, y, z in Q16.16 and a status code. A gaze field at
// the missing marker gives the sentinel on all three coordinates; nearly
// parallel lines give zeros and the degenerate status.
// cfg_wr_en/cfg_wr_data write the tracking distance; the user must do so
// only while idle (not enforced by the block). The pipeline has 12 stages
// of products and sums, a 34-stage restoring divider (a load stage, then
// one quotient bit per stage, three lanes sharing the denominator) and two
// stages of rounding and saturation. It takes one word per cycle if unstalled.
// When the receiver holds m_ready low with a word waiting, the whole
// pipeline freezes and s_ready drops; nothing is lost or repeated.
// Reset (synchronous, aresetn low) empties the pipeline and sets the
// tracking distance to 1024.
// ----------------------------------------------------------------------------
module binocular_vergence_point_core (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [15:0]               cfg_wr_data,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [19:0]        s_left_gaze_x,
    input  logic signed [19:0]        s_left_gaze_y,
    input  logic signed [19:0]        s_right_gaze_x,
    input  logic signed [19:0]        s_right_gaze_y,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [31:0]        m_vergence_x,
    output logic signed [31:0]        m_vergence_y,
    output logic signed [31:0]        m_vergence_z,
    output logic [1:0]                m_result_status
);
    import bvp_pkg::*;

    localparam int LAT = 12 + QB + 3;

    logic           en;
    logic [LAT-1:0] vld_reg;
    logic [TDW-1:0] td_reg;
    logic [TDW-1:0] td_eff;

    // front end
    logic signed [GW-1:0]   lx0_reg, ly0_reg, rx0_reg, ry0_reg;
    logic signed [SSW-1:0]  s0_reg;
    logic                   miss0_reg;
    geo_t                   geo1_reg, geo2_reg, geo3_reg, geo4_reg, geo5_reg, geo6_reg;
    geo_t                   geo7_reg;
    geo_t                   geo1_next;
    logic signed [AMCW-1:0] amc1_reg, amc2_reg, amc3_reg, amc4_reg;
    logic signed [DMBW-1:0] dmb1_reg;

    logic signed [CW+GW-1:0]     cb3;
    logic signed [GW+AW-1:0]     da3;
    logic signed [S2W-1:0]       ssq3;
    logic signed [2*AMCW-1:0]    amcsq3;
    logic signed [2*DMBW-1:0]    dmbsq3;

    logic signed [EW-1:0]   e4_reg;
    logic signed [SQW-1:0]  sq4_reg;
    logic signed [S2W-1:0]  s2_4_reg;

    logic signed [S2W+SQW-1:0]   s2sq6;
    logic signed [2*EW-1:0]      ee6;
    logic signed [S2W+AMCW-1:0]  s2amc6;
    logic signed [GW+EW-1:0]     be6;
    logic signed [GW+EW-1:0]     de6;
    logic signed [S4W-1:0]       s4_6;

    logic signed [QW-1:0]   q7_reg, q8_reg, q9_reg;
    logic signed [UAW-1:0]  ua7_reg, ub7_reg;
    logic signed [SUW-1:0]  su7_reg;
    logic signed [S4W-1:0]  s4_7_reg, s4_8_reg, s4_9_reg;
    logic                   miss8_reg, miss9_reg;

    logic signed [Q6W-1:0]       q6m9;
    logic signed [CW+UAW-1:0]    cua9;
    logic signed [AW+UAW-1:0]    aub9;
    logic signed [GW+UAW-1:0]    dua9;
    logic signed [GW+UAW-1:0]    bub9;
    logic signed [SSW+SUW-1:0]   ssu9;

    logic signed [NW-1:0]   num10_reg [3];
    logic signed [QW-1:0]   q10_reg;
    logic                   deg10_reg, miss10_reg;
    logic signed [TW-1:0]   t11_reg [3];
    logic [DW-1:0]          den11_reg;
    logic                   deg11_reg, miss11_reg;

    // divider
    logic [RW-1:0] dr_reg    [QB+1][3];
    logic [QB-1:0] dq_reg    [QB+1][3];
    logic [2:0]    dneg_reg  [QB+1];
    logic [2:0]    dovf_reg  [QB+1];
    logic [DW-1:0] dden_reg  [QB+1];
    logic          ddeg_reg  [QB+1];
    logic          dmiss_reg [QB+1];

    // back end
    logic signed [VW-1:0] val_reg [3];
    logic signed [VW-1:0] val_next [3];
    logic                 fdeg_reg, fmiss_reg;
    logic [OUTW-1:0]      vx_reg, vy_reg, vz_reg;
    logic [OUTW-1:0]      vx_next, vy_next, vz_next;
    status_t              st_reg, st_next;

    assign en      = !vld_reg[LAT-1] || m_ready;
    assign s_ready = en;
    assign td_eff  = (td_reg == '0) ? TDW'(1) : td_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
            td_reg  <= TD_RESET;
        end else begin
            if (en) begin
                vld_reg <= {vld_reg[LAT-2:0], s_valid};
            end
            if (cfg_wr_en) begin
                td_reg <= cfg_wr_data;
            end
        end
    end

    always_comb begin
        geo1_next.a    = AW'(lx0_reg) + AW'(s0_reg);
        geo1_next.b    = ly0_reg;
        geo1_next.c    = CW'(rx0_reg) - (CW'(s0_reg) <<< 1);
        geo1_next.d    = ry0_reg;
        geo1_next.s    = s0_reg;
        geo1_next.miss = miss0_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lx0_reg   <= s_left_gaze_x;
            ly0_reg   <= s_left_gaze_y;
            rx0_reg   <= s_right_gaze_x;
            ry0_reg   <= s_right_gaze_y;
            s0_reg    <= SSW'(td_eff) << IN_FRAC_BITS;
            miss0_reg <= (s_left_gaze_x == MISS_CODE) || (s_left_gaze_y == MISS_CODE) ||
                         (s_right_gaze_x == MISS_CODE) || (s_right_gaze_y == MISS_CODE);

            geo1_reg <= geo1_next;
            amc1_reg <= AMCW'(lx0_reg) - AMCW'(rx0_reg) + AMCW'(s0_reg)
                        + (AMCW'(s0_reg) <<< 1);
            dmb1_reg <= DMBW'(ry0_reg) - DMBW'(ly0_reg);

            geo2_reg <= geo1_reg;
            geo3_reg <= geo2_reg;
            amc2_reg <= amc1_reg;
            amc3_reg <= amc2_reg;

            geo4_reg <= geo3_reg;
            amc4_reg <= amc3_reg;
            e4_reg   <= EW'(cb3) - EW'(da3);
            sq4_reg  <= SQW'(amcsq3) + SQW'(dmbsq3);
            s2_4_reg <= ssq3;

            geo5_reg <= geo4_reg;
            geo6_reg <= geo5_reg;

            geo7_reg <= geo6_reg;
            q7_reg   <= QW'(s2sq6) + QW'(ee6);
            ua7_reg  <= UAW'(s2amc6) - UAW'(be6);
            ub7_reg  <= UAW'(s2amc6) - UAW'(de6);
            su7_reg  <= SUW'(s2amc6) + SUW'(s2amc6) - SUW'(be6) - SUW'(de6);
            s4_7_reg <= s4_6;

            q8_reg    <= q7_reg;
            q9_reg    <= q8_reg;
            s4_8_reg  <= s4_7_reg;
            s4_9_reg  <= s4_8_reg;
            miss8_reg <= geo7_reg.miss;
            miss9_reg <= miss8_reg;

            num10_reg[0] <= NW'(cua9) + NW'(aub9);
            num10_reg[1] <= NW'(dua9) + NW'(bub9);
            num10_reg[2] <= NW'(ssu9);
            q10_reg      <= q9_reg;
            deg10_reg    <= q6m9 <= Q6W'(s4_9_reg);
            miss10_reg   <= miss9_reg;

            for (int ch = 0; ch < 3; ch++) begin
                t11_reg[ch] <= (TW'(num10_reg[ch]) <<< OUT_FRAC_BITS) + TW'(q10_reg);
            end
            den11_reg  <= DW'(q10_reg) << 1;
            deg11_reg  <= deg10_reg;
            miss11_reg <= miss10_reg;

            for (int ch = 0; ch < 3; ch++) begin
                dr_reg[0][ch]   <= t11_reg[ch][TW-1] ? RW'(-t11_reg[ch])
                                                     : RW'(t11_reg[ch]);
                dq_reg[0][ch]   <= '0;
                dneg_reg[0][ch] <= t11_reg[ch][TW-1];
            end
            dovf_reg[0]  <= '0;
            dden_reg[0]  <= den11_reg;
            ddeg_reg[0]  <= deg11_reg;
            dmiss_reg[0] <= miss11_reg;
        end
    end

    bvp_mul #(.WA(CW),   .WB(GW))   u_cb   (.aclk, .en, .a(geo1_reg.c), .b(geo1_reg.b), .p(cb3));
    bvp_mul #(.WA(GW),   .WB(AW))   u_da   (.aclk, .en, .a(geo1_reg.d), .b(geo1_reg.a), .p(da3));
    bvp_mul #(.WA(SSW),  .WB(SSW))  u_ss   (.aclk, .en, .a(geo1_reg.s), .b(geo1_reg.s), .p(ssq3));
    bvp_mul #(.WA(AMCW), .WB(AMCW)) u_amc  (.aclk, .en, .a(amc1_reg), .b(amc1_reg), .p(amcsq3));
    bvp_mul #(.WA(DMBW), .WB(DMBW)) u_dmb  (.aclk, .en, .a(dmb1_reg), .b(dmb1_reg), .p(dmbsq3));

    bvp_mul #(.WA(S2W),  .WB(SQW))  u_s2sq (.aclk, .en, .a(s2_4_reg), .b(sq4_reg), .p(s2sq6));
    bvp_mul #(.WA(EW),   .WB(EW))   u_ee   (.aclk, .en, .a(e4_reg), .b(e4_reg), .p(ee6));
    bvp_mul #(.WA(S2W),  .WB(AMCW)) u_s2am (.aclk, .en, .a(s2_4_reg), .b(amc4_reg), .p(s2amc6));
    bvp_mul #(.WA(GW),   .WB(EW))   u_be   (.aclk, .en, .a(geo4_reg.b), .b(e4_reg), .p(be6));
    bvp_mul #(.WA(GW),   .WB(EW))   u_de   (.aclk, .en, .a(geo4_reg.d), .b(e4_reg), .p(de6));
    bvp_mul #(.WA(S2W),  .WB(S2W))  u_s4   (.aclk, .en, .a(s2_4_reg), .b(s2_4_reg), .p(s4_6));

    bvp_mul #(.WA(QW),   .WB(MILW)) u_qm   (.aclk, .en, .a(q7_reg), .b(ONE_MILLION), .p(q6m9));
    bvp_mul #(.WA(CW),   .WB(UAW))  u_cua  (.aclk, .en, .a(geo7_reg.c), .b(ua7_reg), .p(cua9));
    bvp_mul #(.WA(AW),   .WB(UAW))  u_aub  (.aclk, .en, .a(geo7_reg.a), .b(ub7_reg), .p(aub9));
    bvp_mul #(.WA(GW),   .WB(UAW))  u_dua  (.aclk, .en, .a(geo7_reg.d), .b(ua7_reg), .p(dua9));
    bvp_mul #(.WA(GW),   .WB(UAW))  u_bub  (.aclk, .en, .a(geo7_reg.b), .b(ub7_reg), .p(bub9));
    bvp_mul #(.WA(SSW),  .WB(SUW))  u_ssu  (.aclk, .en, .a(geo7_reg.s), .b(su7_reg), .p(ssu9));

    // one quotient bit per stage, msb first
    for (genvar k = 0; k < QB; k++) begin : g_div
        localparam int SH = QB - 1 - k;
        logic [RW-1:0] dsh;
        logic [RW-1:0] r_next [3];
        logic [QB-1:0] q_next [3];
        logic [2:0]    ovf_next;

        assign dsh = RW'(dden_reg[k]) << SH;

        always_comb begin
            for (int ch = 0; ch < 3; ch++) begin
                q_next[ch] = dq_reg[k][ch];
                if (dr_reg[k][ch] >= dsh) begin
                    r_next[ch]     = dr_reg[k][ch] - dsh;
                    q_next[ch][SH] = 1'b1;
                end else begin
                    r_next[ch] = dr_reg[k][ch];
                end
                if (k == 0) begin
                    ovf_next[ch] = dr_reg[k][ch] >= (RW'(dden_reg[k]) << QB);
                end else begin
                    ovf_next[ch] = dovf_reg[k][ch];
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                for (int ch = 0; ch < 3; ch++) begin
                    dr_reg[k+1][ch] <= r_next[ch];
                    dq_reg[k+1][ch] <= q_next[ch];
                end
                dneg_reg[k+1]  <= dneg_reg[k];
                dovf_reg[k+1]  <= ovf_next;
                dden_reg[k+1]  <= dden_reg[k];
                ddeg_reg[k+1]  <= ddeg_reg[k];
                dmiss_reg[k+1] <= dmiss_reg[k];
            end
        end
    end

    // floor of the signed quotient
    always_comb begin
        logic [QB:0] mag;
        for (int ch = 0; ch < 3; ch++) begin
            if (dovf_reg[QB][ch]) begin
                mag = (QB+1)'(1) << QB;
            end else begin
                mag = (QB+1)'(dq_reg[QB][ch])
                      + (QB+1)'(dneg_reg[QB][ch] && (dr_reg[QB][ch] != '0));
            end
            val_next[ch] = dneg_reg[QB][ch] ? -VW'(mag) : VW'(mag);
        end
    end

    always_comb begin
        vx_next = sat32((VW+1)'(val_reg[0]) + (VW+1)'(X_BIAS));
        vy_next = sat32((VW+1)'(val_reg[1]));
        vz_next = sat32((VW+1)'(val_reg[2]) + (VW+1)'(Z_BIAS));
        st_next = ST_COMPUTED;
        if (fmiss_reg) begin
            vx_next = SENTINEL;
            vy_next = SENTINEL;
            vz_next = SENTINEL;
            st_next = ST_MISSING;
        end else if (fdeg_reg) begin
            vx_next = '0;
            vy_next = '0;
            vz_next = '0;
            st_next = ST_DEGENERATE;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int ch = 0; ch < 3; ch++) begin
                val_reg[ch] <= val_next[ch];
            end
            fdeg_reg  <= ddeg_reg[QB];
            fmiss_reg <= dmiss_reg[QB];
            vx_reg    <= vx_next;
            vy_reg    <= vy_next;
            vz_reg    <= vz_next;
            st_reg    <= st_next;
        end
    end

    assign m_valid         = vld_reg[LAT-1];
    assign m_vergence_x    = vx_reg;
    assign m_vergence_y    = vy_reg;
    assign m_vergence_z    = vz_reg;
    assign m_result_status = st_reg;

endmodule

// ===== hdl/bvp_mul.sv =====
// ----------------------------------------------------------------------------
// bvp_mul
// Two-stage signed multiplier built from registered 24x24 partial products.
// ----------------------------------------------------------------------------
module bvp_mul #(
    parameter int WA = 24,
    parameter int WB = 24
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic signed [WA-1:0]     a,
    input  logic signed [WB-1:0]     b,
    output logic signed [WA+WB-1:0]  p
);
    import bvp_pkg::*;

    localparam int CH  = MUL_CHUNK;
    localparam int NA  = (WA + CH - 1) / CH;
    localparam int NB  = (WB + CH - 1) / CH;
    localparam int PAW = NA * CH;
    localparam int PBW = NB * CH;
    localparam int PW  = WA + WB;

    logic [WA-1:0]        mag_a;
    logic [WB-1:0]        mag_b;
    logic [PAW-1:0]       pad_a;
    logic [PBW-1:0]       pad_b;
    logic [2*CH-1:0]      pp_reg [NA][NB];
    logic                 neg_reg;
    logic [PW-1:0]        acc;
    logic signed [PW-1:0] p_reg;
    logic signed [PW-1:0] p_next;

    assign mag_a = a[WA-1] ? (~a + 1'b1) : a;
    assign mag_b = b[WB-1] ? (~b + 1'b1) : b;
    assign pad_a = PAW'(mag_a);
    assign pad_b = PBW'(mag_b);

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < NA; i++) begin
                for (int j = 0; j < NB; j++) begin
                    pp_reg[i][j] <= pad_a[i*CH +: CH] * pad_b[j*CH +: CH];
                end
            end
            neg_reg <= a[WA-1] ^ b[WB-1];
            p_reg   <= p_next;
        end
    end

    always_comb begin
        acc = '0;
        for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
                acc = acc + (PW'(pp_reg[i][j]) << (CH * (i + j)));
            end
        end
        p_next = neg_reg ? (~acc + 1'b1) : acc;
    end

    assign p = p_reg;

endmodule

// ===== tb/binocular_vergence_point_core_test.sv =====
// ----------------------------------------------------------------------------
// binocular_vergence_point_core_test
// Self-checking bench for the binocular vergence point core.
// ----------------------------------------------------------------------------
// Gaze words go in with random bursts and gaps while the result side stalls
// on its own pattern. Each accepted word is run through an exact wide-integer
// model of the closest-point geometry, and every result word is compared
// field by field with the oldest prediction. The tracking distance is moved
// through its extremes between phases while the core is idle.
// ----------------------------------------------------------------------------
module binocular_vergence_point_core_test;
    import bvp_pkg::*;

    typedef logic signed [255:0] wide_t;

    typedef struct {
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] vz;
        status_t            status;
    } vergence_t;

    localparam int LIMIT_CYCLES = 400000;
    localparam int TAIL_CYCLES  = 80;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [15:0]        cfg_wr_data = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [19:0] s_left_gaze_x = '0;
    logic signed [19:0] s_left_gaze_y = '0;
    logic signed [19:0] s_right_gaze_x = '0;
    logic signed [19:0] s_right_gaze_y = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [31:0] m_vergence_x;
    logic signed [31:0] m_vergence_y;
    logic signed [31:0] m_vergence_z;
    logic [1:0]         m_result_status;

    vergence_t   pending_points[$];
    logic [15:0] model_distance = TD_RESET;
    int          mismatches = 0;
    int          cycle_count = 0;
    int          hold_cycles = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    binocular_vergence_point_core u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_left_gaze_x   (s_left_gaze_x),
        .s_left_gaze_y   (s_left_gaze_y),
        .s_right_gaze_x  (s_right_gaze_x),
        .s_right_gaze_y  (s_right_gaze_y),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_vergence_x    (m_vergence_x),
        .m_vergence_y    (m_vergence_y),
        .m_vergence_z    (m_vergence_z),
        .m_result_status (m_result_status)
    );

    function automatic logic signed [31:0] clamp32(input wide_t v);
        if (v > wide_t'(64'sd2147483647)) return 32'sh7fffffff;
        if (v < -wide_t'(64'sd2147483648)) return 32'sh80000000;
        return v[31:0];
    endfunction

    // floor(num * 2^16 / (2q) + 1/2)
    function automatic wide_t round_ratio(input wide_t num, input wide_t q);
        wide_t t;
        wide_t den;
        wide_t quo;
        t = (num <<< OUT_FRAC_BITS) + q;
        den = q + q;
        quo = t / den;
        if ((t % den) != 0 && t < 0) quo = quo - 1;
        return quo;
    endfunction

    function automatic vergence_t predict_vergence(input logic signed [19:0] lx,
                                                   input logic signed [19:0] ly,
                                                   input logic signed [19:0] rx,
                                                   input logic signed [19:0] ry,
                                                   input logic [15:0] track_dist);
        vergence_t r;
        wide_t s, a, b, c, d, e, amc, dmb, s2, q, ua, ub, num;
        if (lx == MISS_CODE || ly == MISS_CODE || rx == MISS_CODE || ry == MISS_CODE) begin
            r.vx = SENTINEL;
            r.vy = SENTINEL;
            r.vz = SENTINEL;
            r.status = ST_MISSING;
            return r;
        end
        s = wide_t'((track_dist == 0) ? 17'd1 : {1'b0, track_dist}) <<< IN_FRAC_BITS;
        a = wide_t'(lx) + s;
        b = wide_t'(ly);
        c = wide_t'(rx) - 2 * s;
        d = wide_t'(ry);
        e = c * b - d * a;
        amc = a - c;
        dmb = d - b;
        s2 = s * s;
        q = s2 * (dmb * dmb + amc * amc) + e * e;
        if (q * 1000000 <= s2 * s2) begin
            r.vx = '0;
            r.vy = '0;
            r.vz = '0;
            r.status = ST_DEGENERATE;
            return r;
        end
        ua = s2 * amc - b * e;
        ub = s2 * amc - d * e;
        num = c * ua + a * ub;
        r.vx = clamp32(round_ratio(num, q) + X_BIAS);
        num = d * ua + b * ub;
        r.vy = clamp32(round_ratio(num, q));
        num = s * (ua + ub);
        r.vz = clamp32(round_ratio(num, q) + Z_BIAS);
        r.status = ST_COMPUTED;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("mismatch %s: got %h want %h", what, got, want);
    endtask

    // checker: handshake values are stable at the falling edge
    always @(negedge aclk) begin
        vergence_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_points.size() == 0) begin
                report_mismatch("unexpected word", m_result_status, 0);
            end else begin
                want = pending_points.pop_front();
                if (m_vergence_x !== want.vx) report_mismatch("x", m_vergence_x, want.vx);
                if (m_vergence_y !== want.vy) report_mismatch("y", m_vergence_y, want.vy);
                if (m_vergence_z !== want.vz) report_mismatch("z", m_vergence_z, want.vz);
                if (m_result_status !== want.status)
                    report_mismatch("status", m_result_status, want.status);
            end
        end
    end

    // receiver stall pattern, with an optional long hold-off
    always @(posedge aclk) begin
        int mode;
        int left;
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_ready <= 1'b0;
        end else begin
            if (left == 0) begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(5, 60);
            end
            left = left - 1;
            case (mode)
                0: m_ready <= 1'b1;
                1: m_ready <= ($urandom_range(0, 1) == 0);
                2: m_ready <= ($urandom_range(0, 3) == 0);
                default: m_ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // called at a rising edge, returns at the edge where the word is taken
    task automatic send_gaze(input logic signed [19:0] lx, input logic signed [19:0] ly,
                             input logic signed [19:0] rx, input logic signed [19:0] ry);
        s_left_gaze_x <= lx;
        s_left_gaze_y <= ly;
        s_right_gaze_x <= rx;
        s_right_gaze_y <= ry;
        s_valid <= 1'b1;
        @(negedge aclk);
        while (!s_ready) @(negedge aclk);
        pending_points.push_back(predict_vergence(lx, ly, rx, ry, model_distance));
        @(posedge aclk);
    endtask

    task automatic idle_sender(input int cycles);
        s_valid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_points.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    task automatic write_distance(input logic [15:0] new_dist);
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= new_dist;
        @(posedge aclk);
        model_distance = new_dist;
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic signed [19:0] rand_field();
        return 20'($urandom);
    endfunction

    // gaze near the screen so the lines actually cross
    function automatic logic signed [19:0] rand_near(input int span);
        int v;
        v = $urandom_range(0, 2 * span) - span;
        return 20'(v);
    endfunction

    task automatic send_random(input int span);
        logic signed [19:0] f[4];
        int pick;
        pick = $urandom_range(0, 19);
        for (int i = 0; i < 4; i++) f[i] = (pick < 14) ? rand_near(span) : rand_field();
        if (pick == 19) f[$urandom_range(0, 3)] = MISS_CODE;
        if (pick == 18) begin
            f[2] = f[0] + 20'(3 * (model_distance == 0 ? 1 : model_distance) * 16);
            f[3] = f[1];
        end
        send_gaze(f[0], f[1], f[2], f[3]);
    endtask

    task automatic test_extremes();
        send_gaze(0, 0, 0, 0);
        send_gaze(20'sd524287, 20'sd524287, 20'sd524287, 20'sd524287);
        send_gaze(-20'sd524287, -20'sd524287, -20'sd524287, -20'sd524287);
        send_gaze(20'sd524287, -20'sd524287, -20'sd524287, 20'sd524287);
        send_gaze(-20'sd524287, 20'sd524287, 20'sd524287, -20'sd524287);
        send_gaze(-20'sd16384, 0, 20'sd32768, 0);
        send_gaze(20'sd1, -20'sd1, -20'sd1, 20'sd1);
        idle_sender(3);
    endtask

    task automatic test_missing_eye();
        send_gaze(MISS_CODE, 0, 0, 0);
        send_gaze(0, MISS_CODE, 0, 0);
        send_gaze(0, 0, MISS_CODE, 0);
        send_gaze(0, 0, 0, MISS_CODE);
        send_gaze(MISS_CODE, MISS_CODE, MISS_CODE, MISS_CODE);
        idle_sender(2);
    endtask

    task automatic test_parallel_lines();
        // equal directions: right x three distance units right of left x
        send_gaze(0, 0, 20'sd49152, 0);
        send_gaze(20'sd100, 20'sd500, 20'sd49252, 20'sd500);
        send_gaze(0, 0, 20'sd49153, 0);
        send_gaze(0, 20'sd1, 20'sd49152, 0);
        idle_sender(1);
    endtask

    task automatic test_random_bursts(input int count, input int span);
        int burst;
        while (count > 0) begin
            burst = $urandom_range(1, 20);
            repeat (burst) begin
                if (count > 0) send_random(span);
                count--;
            end
            if ($urandom_range(0, 2) != 0) idle_sender($urandom_range(1, 6));
        end
        s_valid <= 1'b0;
    endtask

    task automatic test_distance_sweep();
        write_distance(16'd1);
        test_random_bursts(70, 64);
        write_distance(16'd65535);
        test_random_bursts(70, 524287);
        write_distance(16'd0);
        test_random_bursts(50, 48);
        write_distance(16'($urandom_range(2, 65534)));
        test_random_bursts(80, 40000);
        write_distance(TD_RESET);
    endtask

    task automatic test_backpressure();
        wait_drained();
        hold_cycles = 300;
        test_random_bursts(120, 30000);
    endtask

    task automatic test_drain_pause();
        test_random_bursts(40, 30000);
        wait_drained();
        test_random_bursts(40, 30000);
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_extremes();
        test_missing_eye();
        test_parallel_lines();
        test_random_bursts(60, 30000);
        test_distance_sweep();
        test_backpressure();
        test_drain_pause();
        wait_drained();
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
